/* rtl/core/esae_pkg.sv */
`default_nettype none
package esae_pkg;

  localparam int ENC_W      = 16;
  localparam int DIV_W      = 9;
  localparam int CNT_W      = 14;
  localparam int GAIN_W     = 16;
  localparam int PP_W       = 5;
  localparam int DELTA_W    = 14;
  localparam int MECH_W     = 22;
  localparam int ELEC_W     = 26;
  localparam int ANGLE_W    = 16;
  localparam int TICK_W     = 8;
  localparam int Q_SHIFT    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_DIVIDER = 3'd0,
    REG_COUNTS_PER_REV = 3'd1,
    REG_ELEC_COUNTS    = 3'd2,
    REG_SPEED_GAIN     = 3'd3,
    REG_POLE_PAIRS     = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SEL  = 4'b0010,
    ST_CALC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/esae_ser_mul.sv */
`default_nettype none
// Radix-2 shift-add multiplier: signed a times unsigned b, one bit of b per cycle.
module esae_ser_mul #(
  parameter int AW = 14,
  parameter int BW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic [BW-1:0]        b,
  output logic                      busy,
  output logic                      done,
  output logic signed [AW+BW-1:0]   prod
);
  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0] a_r;
  logic [AW-1:0]        hi;
  logic [BW-1:0]        lo;
  logic [CW-1:0]        cnt;
  logic [AW:0]          sum;

  always_comb begin
    sum = {hi[AW-1], hi} + (lo[0] ? {a_r[AW-1], a_r} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= sum[AW:1];
      lo <= {sum[0], lo[BW-1:1]};
    end
  end

  assign prod = $signed({hi, lo});

endmodule
`default_nettype wire

/* rtl/core/esae_frac_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle. Divides count * 2^16 by the
// modulus; the low 16 quotient bits are the turn fraction of (count mod modulus).
module esae_frac_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [esae_pkg::ENC_W-1:0]    count,
  input  wire logic [esae_pkg::CNT_W-1:0]    modulus,
  output logic                               done,
  output logic [esae_pkg::ANGLE_W-1:0]       frac
);
  import esae_pkg::*;

  localparam int STEPS = ENC_W + ANGLE_W;
  localparam int SW    = $clog2(STEPS);

  logic [STEPS-1:0] dvd;
  logic [CNT_W-1:0] dsr;
  logic [CNT_W-1:0] rem;
  logic [ANGLE_W-1:0] quo;
  logic             zero_mod;
  logic             busy;
  logic [SW-1:0]    cnt;
  logic [CNT_W:0]   rem2;
  logic [CNT_W:0]   diff;
  logic             qbit;

  always_comb begin
    rem2 = {rem, dvd[STEPS-1]};
    diff = rem2 - {1'b0, dsr};
    qbit = (rem2 >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + SW'(1);
        if (cnt == SW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= {count, {ANGLE_W{1'b0}}};
      dsr      <= modulus;
      zero_mod <= (modulus == '0);
      rem      <= '0;
      quo      <= '0;
    end else if (busy) begin
      dvd <= {dvd[STEPS-2:0], 1'b0};
      rem <= qbit ? diff[CNT_W-1:0] : rem2[CNT_W-1:0];
      quo <= {quo[ANGLE_W-2:0], qbit};
    end
  end

  // zero modulus reads as angle zero
  assign frac = zero_mod ? '0 : quo;

endmodule
`default_nettype wire

/* rtl/core/encoder_speed_angle_estimator_top.sv */
`default_nettype none
// A sample tick moves the FSM through ST_SEL, ST_CALC and ST_DONE before its result
// is registered; the 32-step bit-serial angle dividers set the length of ST_CALC.
// in_stall is held from ST_SEL to ST_DONE, so no new tick is taken until the result
// leaves ST_DONE; while idle, non-sample ticks are taken one per cycle.
// A finished result waits in the output register while the next tick is taken.
// Reset (synchronous, active high) restores register defaults and clears state.
module encoder_speed_angle_estimator_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [esae_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [esae_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [esae_pkg::ENC_W-1:0]            encoder_count,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [esae_pkg::DELTA_W-1:0]        count_delta,
  output logic                                       delta_fresh,
  output logic signed [esae_pkg::MECH_W-1:0]         mech_speed,
  output logic signed [esae_pkg::ELEC_W-1:0]         elec_speed,
  output logic [esae_pkg::ANGLE_W-1:0]               mech_angle,
  output logic [esae_pkg::ANGLE_W-1:0]               elec_angle
);
  import esae_pkg::*;

  localparam int CW   = ENC_W + 2;
  localparam int P1W  = DELTA_W + GAIN_W;
  localparam int P2W  = MECH_W + PP_W;

  // configuration
  logic [DIV_W-1:0]  sample_divider;
  logic [CNT_W-1:0]  counts_per_rev;
  logic [CNT_W-1:0]  elec_counts;
  logic [GAIN_W-1:0] speed_gain;
  logic [PP_W-1:0]   pole_pairs;

  state_t state;
  logic [TICK_W-1:0]        tick_count;
  logic [ENC_W-1:0]         prev_count;
  logic [ENC_W-1:0]         enc_reg;
  logic [ENC_W-1:0]         d_reg;
  logic signed [DELTA_W-1:0] last_delta;
  logic                     fresh;

  logic [DIV_W-1:0] div_eff;
  logic             sample_tick;
  logic             in_xfer;
  logic             out_free;

  logic signed [CW-1:0]      c0, c1, c2, n_s;
  logic                      q0, q1, q2;
  logic signed [DELTA_W-1:0] delta_next;

  logic                      start;
  logic                      m1_busy, m1_done, m2_busy, m2_done;
  logic signed [P1W-1:0]     m1_prod;
  logic signed [P2W-1:0]     m2_prod;
  logic signed [MECH_W-1:0]  mech_val;
  logic signed [ELEC_W-1:0]  elec_val;
  logic                      md_done, ed_done;
  logic [ANGLE_W-1:0]        mech_frac, elec_frac;

  function automatic logic qualifies(input logic signed [CW-1:0] c,
                                     input logic signed [CW-1:0] n);
    logic signed [CW:0] tc;
    logic signed [CW:0] nn;
    tc = {c, 1'b0};
    nn = {n[CW-1], n};
    return (tc > -nn) && (tc < nn);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_divider <= DIV_W'(40);
      counts_per_rev <= CNT_W'(5000);
      elec_counts    <= CNT_W'(1250);
      speed_gain     <= GAIN_W'(20588);
      pole_pairs     <= PP_W'(4);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SAMPLE_DIVIDER: sample_divider <= cfg_data[DIV_W-1:0];
        REG_COUNTS_PER_REV: counts_per_rev <= cfg_data[CNT_W-1:0];
        REG_ELEC_COUNTS:    elec_counts    <= cfg_data[CNT_W-1:0];
        REG_SPEED_GAIN:     speed_gain     <= cfg_data[GAIN_W-1:0];
        REG_POLE_PAIRS:     pole_pairs     <= cfg_data[PP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sample_divider == '0) begin
      div_eff = DIV_W'(1);
    end else if (sample_divider > DIV_W'(256)) begin
      div_eff = DIV_W'(256);
    end else begin
      div_eff = sample_divider;
    end
    sample_tick = ({1'b0, tick_count} + DIV_W'(1)) >= div_eff;
  end

  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // wrap-corrected delta: at most one of the three candidates can qualify
  always_comb begin
    n_s = $signed({{(CW - CNT_W){1'b0}}, counts_per_rev});
    c0  = $signed({{(CW - ENC_W){d_reg[ENC_W-1]}}, d_reg});
    c1  = c0 + n_s;
    c2  = c0 - n_s;
    q0  = qualifies(c0, n_s);
    q1  = qualifies(c1, n_s);
    q2  = qualifies(c2, n_s);
    if (q2) begin
      delta_next = c2[DELTA_W-1:0];
    end else if (q1) begin
      delta_next = c1[DELTA_W-1:0];
    end else if (q0) begin
      delta_next = c0[DELTA_W-1:0];
    end else begin
      delta_next = last_delta;
    end
  end

  assign start = (state == ST_SEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      prev_count <= '0;
      last_delta <= '0;
      out_valid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            if (sample_tick) begin
              tick_count <= '0;
              prev_count <= encoder_count;
              state      <= ST_SEL;
            end else begin
              tick_count <= tick_count + TICK_W'(1);
            end
          end
        end
        ST_SEL: begin
          last_delta <= delta_next;
          state      <= ST_CALC;
        end
        ST_CALC: begin
          if (md_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && sample_tick) begin
      enc_reg <= encoder_count;
      d_reg   <= encoder_count - prev_count;
    end
    if (state == ST_SEL) begin
      fresh <= q0 || q1 || q2;
    end
  end

  esae_ser_mul #(.AW(DELTA_W), .BW(GAIN_W)) u_mech_mul (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .a     (delta_next),
    .b     (speed_gain),
    .busy  (m1_busy),
    .done  (m1_done),
    .prod  (m1_prod)
  );

  // floor divide by 256 is the arithmetic shift
  assign mech_val = m1_prod[MECH_W+Q_SHIFT-1:Q_SHIFT];

  esae_ser_mul #(.AW(MECH_W), .BW(PP_W)) u_elec_mul (
    .clk   (clk),
    .rst   (rst),
    .start (m1_done),
    .a     (mech_val),
    .b     (pole_pairs),
    .busy  (m2_busy),
    .done  (m2_done),
    .prod  (m2_prod)
  );

  always_comb begin
    if (m2_prod[P2W-1:ELEC_W-1] == '0 || m2_prod[P2W-1:ELEC_W-1] == '1) begin
      elec_val = m2_prod[ELEC_W-1:0];
    end else if (m2_prod[P2W-1]) begin
      elec_val = {1'b1, {(ELEC_W - 1){1'b0}}};
    end else begin
      elec_val = {1'b0, {(ELEC_W - 1){1'b1}}};
    end
  end

  esae_frac_div u_mech_div (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .count   (enc_reg),
    .modulus (counts_per_rev),
    .done    (md_done),
    .frac    (mech_frac)
  );

  esae_frac_div u_elec_div (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .count   (enc_reg),
    .modulus (elec_counts),
    .done    (ed_done),
    .frac    (elec_frac)
  );

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      count_delta <= last_delta;
      delta_fresh <= fresh;
      mech_speed  <= mech_val;
      elec_speed  <= elec_val;
      mech_angle  <= mech_frac;
      elec_angle  <= elec_frac;
    end
  end

  // both multiplies must be finished before the angle dividers complete
  a_mul_before_div: assert property (@(posedge clk) disable iff (rst)
    md_done |-> !m1_busy && !m2_busy && !m2_done)
    else $error("speed multiply still running at divider completion");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    md_done == ed_done)
    else $error("angle dividers out of step");

  a_sample_to_sel: assert property (@(posedge clk) disable iff (rst)
    in_xfer && sample_tick |=> state == ST_SEL)
    else $error("sample tick did not start a calculation");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result presented without a finished calculation");

endmodule
`default_nettype wire
